/* design/zpes_pkg.sv */
// ----------------------------------------------------------------------------
// zpes_pkg: shared definitions for the zero-padded exponential search
// Field widths, command codes, register reset value and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package zpes_pkg;

  // parameter defaults
  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 16;

  // request and result field widths
  localparam int CMD_W    = 1;
  localparam int SLOT_W   = 10;
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 10;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 11;

  // configuration register reset
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

  // probe counter saturation
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

endpackage

`default_nettype wire

/* design/zpes_ifs.sv */
// ----------------------------------------------------------------------------
// zpes channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel: write one entry or search for a key
interface zpes_in_if;
  logic                         valid;
  logic                         ready;
  logic [zpes_pkg::CMD_W-1:0]   cmd;
  logic [zpes_pkg::SLOT_W-1:0]  slot;
  logic [zpes_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output slot, output value, input ready);
  modport sink   (input valid, input cmd, input slot, input value, output ready);
endinterface

// result channel: one result per search
interface zpes_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [zpes_pkg::POS_W-1:0]   position;
  logic [zpes_pkg::COUNT_W-1:0] probe_count;

  modport source (output valid, output found, output position, output probe_count,
                  input ready);
  modport sink   (input valid, input found, input position, input probe_count,
                  output ready);
endinterface

// configuration write channel: table size register
interface zpes_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [zpes_pkg::CFG_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

`default_nettype wire

/* design/zero_padded_exponential_search.sv */
// ----------------------------------------------------------------------------
// zero_padded_exponential_search: exponential search over a sorted table
// Holds a sorted table where zero marks an empty tail slot. Write requests
// store an entry; search requests double a probe position, clamp it to the
// table size and bisect, returning found flag, index and probe count.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------
//  in_req   | in  | valid / ready | cmd, slot, value
//  out_res  | out | valid / ready | found, position, probe_count
//  cfg_wr   | in  | valid / ready | table_size (always ready)
//
//  a write is stored when taken; a search reads slot 0, then makes doubling and
//  then bisection reads, one per cycle, or ends after the slot 0 check if slot 0
//  matches or size is 0. after reset a clearing pass zeroes the table with
//  in_req.ready low; configuration writes are taken throughout.
//  the result register frees the request side: a new request is taken while
//  a result waits, and a finished search holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_padded_exponential_search #(
  parameter int DEPTH      = zpes_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = zpes_pkg::VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  zpes_in_if.sink    in_req,
  zpes_out_if.source out_res,
  zpes_cfg_if.sink   cfg_wr
);

  localparam int AW  = $clog2(DEPTH);
  localparam int PW  = AW + 1;
  localparam int SW  = (PW > zpes_pkg::CFG_W) ? PW : zpes_pkg::CFG_W;
  localparam int LW  = (PW > zpes_pkg::SLOT_W) ? PW : zpes_pkg::SLOT_W;
  localparam int XW  = (PW > zpes_pkg::POS_W) ? PW : zpes_pkg::POS_W;
  localparam int VXW = (VALUE_BITS > zpes_pkg::VALUE_W) ? VALUE_BITS : zpes_pkg::VALUE_W;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CHK0  = 7'b0000100,
    ST_DBL   = 7'b0001000,
    ST_BSET  = 7'b0010000,
    ST_BIS   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [zpes_pkg::CFG_W-1:0]   table_size_r;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [VALUE_BITS-1:0]        key_r, key_nxt;
  logic [PW-1:0]                size_r, size_nxt;
  logic [PW-1:0]                place_r, place_nxt;
  logic [PW-1:0]                low_r, low_nxt;
  logic [PW-1:0]                high_r, high_nxt;
  logic [PW-1:0]                mid_r, mid_nxt;
  logic [zpes_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [PW-1:0]                res_pos_r, res_pos_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r;
  logic [zpes_pkg::POS_W-1:0]   out_pos_r;
  logic [zpes_pkg::COUNT_W-1:0] out_count_r;

  // ram ports
  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [VALUE_BITS-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_rd_data;

  // request decode
  logic                  in_take;
  logic [LW-1:0]         slot_x;
  logic                  slot_ok;
  logic [VXW-1:0]        value_x;
  logic [VALUE_BITS-1:0] value_m;
  logic [SW-1:0]         cfg_x;
  logic [SW-1:0]         size_sat;

  // probe evaluation
  logic                         hit;
  logic                         less;
  logic [zpes_pkg::COUNT_W-1:0] count_inc;
  logic [PW-1:0]                place2;
  logic [PW-1:0]                pc;
  logic [PW-1:0]                b_low;
  logic [PW-1:0]                b_high;
  logic [PW:0]                  b_sum;
  logic                         out_free;
  logic [XW-1:0]                pos_x;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_take      = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  assign slot_x   = LW'(in_req.slot);
  assign slot_ok  = (slot_x < LW'(DEPTH));
  assign value_x  = VXW'(in_req.value);
  assign value_m  = value_x[VALUE_BITS-1:0];
  assign cfg_x    = SW'(table_size_r);
  assign size_sat = (cfg_x > SW'(DEPTH)) ? SW'(DEPTH) : cfg_x;

  assign hit       = (key_r != '0) && (ram_rd_data == key_r);
  assign less      = (ram_rd_data != '0) && (ram_rd_data < key_r);
  assign count_inc = (count_r == zpes_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign place2    = {place_r[PW-2:0], 1'b0};
  assign out_free  = !out_valid_r || out_res.ready;

  // bisection bounds from the clamped probe position
  assign pc     = (place_r > size_r) ? size_r : place_r;
  assign b_low  = pc >> 1;
  assign b_high = pc - 1'b1;
  assign b_sum  = {1'b0, b_low} + {1'b0, b_high};

  // table write: clearing pass or write request
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = in_take && (in_req.cmd == zpes_pkg::CMD_WRITE) && slot_ok;
      ram_wr_addr = slot_x[AW-1:0];
      ram_wr_data = value_m;
    end
  end

  // search sequencer
  always_comb begin
    logic [PW-1:0] nlow;
    logic [PW-1:0] nhigh;
    logic [PW:0]   nsum;
    logic          stop;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    place_nxt     = place_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    count_nxt     = count_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    nlow          = low_r;
    nhigh         = high_r;
    nsum          = '0;
    stop          = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take && (in_req.cmd == zpes_pkg::CMD_SEARCH)) begin
          key_nxt     = value_m;
          size_nxt    = PW'(size_sat);
          count_nxt   = '0;
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
          state_nxt   = ST_CHK0;
        end
      end

      // slot 0 compare, then finish, start doubling or go to bisection setup
      ST_CHK0: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = '0;
          state_nxt     = ST_FIN;
        end else if (size_r == '0) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = ST_FIN;
        end else if (size_r > PW'(1)) begin
          place_nxt   = PW'(1);
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(1);
          state_nxt   = ST_DBL;
        end else begin
          place_nxt = PW'(1);
          state_nxt = ST_BSET;
        end
      end

      // doubling probe
      ST_DBL: begin
        if (less) begin
          count_nxt = count_inc;
          place_nxt = place2;
          if (place2 < size_r) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = place2[AW-1:0];
          end else begin
            state_nxt = ST_BSET;
          end
        end else begin
          state_nxt = ST_BSET;
        end
      end

      // set bisection range and issue first midpoint read
      ST_BSET: begin
        low_nxt     = b_low;
        high_nxt    = b_high;
        mid_nxt     = b_sum[PW:1];
        ram_rd_en   = 1'b1;
        ram_rd_addr = b_sum[AW:1];
        state_nxt   = ST_BIS;
      end

      // bisection probe
      ST_BIS: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = ST_FIN;
        end else begin
          count_nxt = count_inc;
          if (!less && (ram_rd_data == '0 || ram_rd_data >= key_r)) begin
            stop  = (mid_r == low_r);
            nhigh = mid_r - 1'b1;
          end else begin
            stop = (mid_r == high_r);
            nlow = mid_r + 1'b1;
          end
          if (stop) begin
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = ST_FIN;
          end else begin
            nsum        = {1'b0, nlow} + {1'b0, nhigh};
            low_nxt     = nlow;
            high_nxt    = nhigh;
            mid_nxt     = nsum[PW:1];
            ram_rd_en   = 1'b1;
            ram_rd_addr = nsum[AW:1];
          end
        end
      end

      // hand result to the output register
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_res.ready) ||
                         ((state_r == ST_FIN) && out_free);
  assign pos_x = XW'(res_pos_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      table_size_r <= zpes_pkg::TABLE_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        table_size_r <= cfg_wr.table_size;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    size_r      <= size_nxt;
    place_r     <= place_nxt;
    low_r       <= low_nxt;
    high_r      <= high_nxt;
    mid_r       <= mid_nxt;
    count_r     <= count_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    if ((state_r == ST_FIN) && out_free) begin
      out_found_r <= res_found_r;
      out_pos_r   <= pos_x[zpes_pkg::POS_W-1:0];
      out_count_r <= count_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.found       = out_found_r;
  assign out_res.position    = out_pos_r;
  assign out_res.probe_count = out_count_r;

  // table storage
  zpes_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

/* design/zpes_ram.sv */
// ----------------------------------------------------------------------------
// zpes_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module zpes_ram #(
  parameter int WIDTH = zpes_pkg::VALUE_BITS_DEF,
  parameter int DEPTH = zpes_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
